FILE: rtl/salc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// salc_pkg
// Shared types, constants and field positions of the LRU cache model.
// ----------------------------------------------------------------------------
package salc_pkg;

    localparam int SETS_DEF            = 64;
    localparam int WAYS_DEF            = 8;
    localparam int MAX_OFFSET_BITS_DEF = 12;

    localparam int ADDR_W       = 64;
    localparam int KEY_W        = 64;
    localparam int SET_FIELD_W  = 7;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 4;
    localparam int CNT_W        = 32;
    localparam int RES_W        = 22;

    localparam int OUT_HIT_BIT    = 0;
    localparam int OUT_EVICT_BIT  = 1;
    localparam int OUT_WB_BIT     = 2;
    localparam int OUT_HITS_LSB   = 3;
    localparam int OUT_MISS_LSB   = OUT_HITS_LSB + CNT_W;
    localparam int OUT_EVCT_LSB   = OUT_MISS_LSB + CNT_W;
    localparam int OUT_RES_LSB    = OUT_EVCT_LSB + CNT_W;
    localparam int OUT_WBB_LSB    = OUT_RES_LSB + RES_W;
    localparam int OUT_USED_W     = OUT_WBB_LSB + CNT_W;
    localparam int OUT_DATA_W     = ((OUT_USED_W + 7) / 8) * 8;

    localparam logic [2:0] CFG_SET_BITS_RST = 3'd0;
    localparam logic [3:0] CFG_OFF_BITS_RST = 4'd4;
    localparam logic [3:0] CFG_WAYS_RST     = 4'd8;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SET_INDEX_BITS    = 2'd0,
        CFG_BLOCK_OFFSET_BITS = 2'd1,
        CFG_WAYS_IN_USE       = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        logic hit;
        logic evicted;
        logic wb;
        logic dirty_inc;
        logic dirty_dec;
    } t_upd_flags;

endpackage

FILE: rtl/set_assoc_lru_cache_model.sv
`timescale 1ns / 1ps
// Each request passes the set read (ST_READ) and the update (ST_UPDATE) before its result is registered.
// A new request can be accepted during the update of the one before (set read, then update and write back);
// a result that is not taken holds the update and the input.
// Reset clears all counters and runs a pass over all SETS rows
// that zeroes the set memory; no request is accepted during that pass.
// Configuration writes are accepted only while idle, never with a request in flight.
// ----------------------------------------------------------------------------
// set_assoc_lru_cache_model
// Set-associative write-back cache model with true LRU replacement.
// ----------------------------------------------------------------------------
module set_assoc_lru_cache_model
    import salc_pkg::*;
#(
    parameter int SETS            = SETS_DEF,
    parameter int WAYS            = WAYS_DEF,
    parameter int MAX_OFFSET_BITS = MAX_OFFSET_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [ADDR_W-1:0]     s_axis_tdata,   // address[63:0]
    input  logic                  s_axis_tuser,   // kind
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // hit, evicted, dirty_writeback, hit_total[31:0], miss_total[31:0],
    // eviction_total[31:0], dirty_bytes_resident[21:0],
    // dirty_bytes_written_back[31:0], zero fill
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int RW      = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int NW      = $clog2(WAYS + 1);
    localparam int SW      = (SETS > 1) ? $clog2(SETS) : 1;
    localparam int OFS_W   = 5;
    localparam int BYTES_W = MAX_OFFSET_BITS + 1;

    typedef struct packed {
        logic [WAYS-1:0][KEY_W-1:0] tag;
        logic [WAYS*RW-1:0]         rank;
        logic [WAYS-1:0]            dirty;
        logic [WAYS-1:0]            valid;
    } t_row;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_UPDATE
    } t_state;

    t_state               r_state;
    logic [SW-1:0]        r_clr_idx;
    logic [ADDR_W-1:0]    r_addr;
    logic                 r_store;
    logic [KEY_W-1:0]     r_key;
    logic [SW-1:0]        r_set;
    logic [2:0]           r_cfg_set_bits;
    logic [3:0]           r_cfg_off_bits;
    logic [3:0]           r_cfg_ways;
    logic [CNT_W-1:0]     r_hit_cnt;
    logic [CNT_W-1:0]     r_miss_cnt;
    logic [CNT_W-1:0]     r_evct_cnt;
    logic [RES_W-1:0]     r_res_bytes;
    logic [CNT_W-1:0]     r_wb_bytes;
    logic                 r_out_valid;
    logic [OUT_DATA_W-1:0] r_out_data;

    t_row                 r_mem [SETS];
    t_row                 r_rd_row;

    logic [CNT_W-1:0]     n_hit_cnt;
    logic [CNT_W-1:0]     n_miss_cnt;
    logic [CNT_W-1:0]     n_evct_cnt;
    logic [RES_W-1:0]     n_res_bytes;
    logic [CNT_W-1:0]     n_wb_bytes;
    t_row                 n_row;

    logic [OFS_W-1:0]       off_bits;
    logic [BYTES_W-1:0]     blk_bytes;
    logic [NW-1:0]          nways;
    logic [KEY_W-1:0]       key_c;
    logic [SET_FIELD_W-1:0] field_mask;
    logic [SET_FIELD_W-1:0] set_v;
    logic                   in_acc;
    logic                   out_free;
    logic                   upd_fire;
    logic                   mem_we;
    logic [SW-1:0]          mem_waddr;
    t_row                   mem_wdata;
    t_upd_flags             flags;
    logic [RES_W:0]         res_sum;
    logic [CNT_W:0]         wbb_sum;

    assign off_bits  = (int'(r_cfg_off_bits) > MAX_OFFSET_BITS) ?
                       OFS_W'(MAX_OFFSET_BITS) : OFS_W'(r_cfg_off_bits);
    assign blk_bytes = BYTES_W'(1) << off_bits;

    always_comb begin
        if (r_cfg_ways == '0) begin
            nways = NW'(1);
        end else if (int'(r_cfg_ways) > WAYS) begin
            nways = NW'(WAYS);
        end else begin
            nways = NW'(r_cfg_ways);
        end
    end

    assign key_c      = r_addr >> off_bits;
    assign field_mask = SET_FIELD_W'((8'd1 << r_cfg_set_bits) - 8'd1);

    always_comb begin
        set_v = key_c[SET_FIELD_W-1:0] & field_mask;
        for (int k = SET_FIELD_W - 1; k >= 0; k--) begin
            if (32'(set_v) >= (32'(SETS) << k)) begin
                set_v = set_v - SET_FIELD_W'(SETS << k);
            end
        end
    end

    assign out_free      = ~r_out_valid | m_axis_tready;
    assign upd_fire      = (r_state == ST_UPDATE) && out_free;
    assign s_axis_tready = ((r_state == ST_IDLE) && !i_cfg_valid) || upd_fire;
    assign in_acc        = s_axis_tvalid & s_axis_tready;
    assign o_cfg_ready   = (r_state == ST_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    salc_way_update #(
        .WAYS (WAYS)
    ) u_way_update (
        .i_valid (r_rd_row.valid),
        .i_dirty (r_rd_row.dirty),
        .i_rank  (r_rd_row.rank),
        .i_tag   (r_rd_row.tag),
        .i_key   (r_key),
        .i_store (r_store),
        .i_nways (nways),
        .o_valid (n_row.valid),
        .o_dirty (n_row.dirty),
        .o_rank  (n_row.rank),
        .o_tag   (n_row.tag),
        .o_flags (flags)
    );

    assign res_sum = {1'b0, r_res_bytes} + (RES_W + 1)'(blk_bytes);
    assign wbb_sum = {1'b0, r_wb_bytes} + (CNT_W + 1)'(blk_bytes);

    always_comb begin
        n_hit_cnt   = r_hit_cnt;
        n_miss_cnt  = r_miss_cnt;
        n_evct_cnt  = r_evct_cnt;
        n_res_bytes = r_res_bytes;
        n_wb_bytes  = r_wb_bytes;
        if (flags.hit) begin
            n_hit_cnt = (&r_hit_cnt) ? r_hit_cnt : r_hit_cnt + CNT_W'(1);
        end else begin
            n_miss_cnt = (&r_miss_cnt) ? r_miss_cnt : r_miss_cnt + CNT_W'(1);
        end
        if (flags.evicted) begin
            n_evct_cnt = (&r_evct_cnt) ? r_evct_cnt : r_evct_cnt + CNT_W'(1);
        end
        if (flags.wb) begin
            n_wb_bytes = wbb_sum[CNT_W] ? '1 : wbb_sum[CNT_W-1:0];
        end
        if (flags.dirty_inc) begin
            n_res_bytes = res_sum[RES_W] ? '1 : res_sum[RES_W-1:0];
        end else if (flags.dirty_dec) begin
            n_res_bytes = (r_res_bytes < RES_W'(blk_bytes)) ?
                          '0 : r_res_bytes - RES_W'(blk_bytes);
        end
    end

    assign mem_we    = (r_state == ST_CLEAR) || upd_fire;
    assign mem_waddr = (r_state == ST_CLEAR) ? r_clr_idx : r_set;
    assign mem_wdata = (r_state == ST_CLEAR) ? t_row'('0) : n_row;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        if (r_state == ST_READ) begin
            r_rd_row <= r_mem[SW'(set_v)];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= ST_CLEAR;
            r_clr_idx      <= '0;
            r_cfg_set_bits <= CFG_SET_BITS_RST;
            r_cfg_off_bits <= CFG_OFF_BITS_RST;
            r_cfg_ways     <= CFG_WAYS_RST;
            r_hit_cnt      <= '0;
            r_miss_cnt     <= '0;
            r_evct_cnt     <= '0;
            r_res_bytes    <= '0;
            r_wb_bytes     <= '0;
            r_out_valid    <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_SET_INDEX_BITS:    r_cfg_set_bits <= i_cfg_data[2:0];
                    CFG_BLOCK_OFFSET_BITS: r_cfg_off_bits <= i_cfg_data;
                    CFG_WAYS_IN_USE:       r_cfg_ways     <= i_cfg_data;
                    default: ;
                endcase
            end
            if (r_out_valid && m_axis_tready && !upd_fire) begin
                r_out_valid <= 1'b0;
            end
            if (in_acc) begin
                r_addr  <= s_axis_tdata;
                r_store <= s_axis_tuser;
            end
            case (r_state)
                ST_CLEAR: begin
                    if (int'(r_clr_idx) == SETS - 1) begin
                        r_state <= ST_IDLE;
                    end else begin
                        r_clr_idx <= r_clr_idx + SW'(1);
                    end
                end
                ST_IDLE: begin
                    if (in_acc) begin
                        r_state <= ST_READ;
                    end
                end
                ST_READ: begin
                    r_key   <= key_c;
                    r_set   <= SW'(set_v);
                    r_state <= ST_UPDATE;
                end
                ST_UPDATE: begin
                    if (upd_fire) begin
                        r_hit_cnt   <= n_hit_cnt;
                        r_miss_cnt  <= n_miss_cnt;
                        r_evct_cnt  <= n_evct_cnt;
                        r_res_bytes <= n_res_bytes;
                        r_wb_bytes  <= n_wb_bytes;
                        r_out_valid <= 1'b1;
                        r_out_data  <= OUT_DATA_W'({n_wb_bytes, n_res_bytes, n_evct_cnt,
                                                    n_miss_cnt, n_hit_cnt, flags.wb,
                                                    flags.evicted, flags.hit});
                        r_state     <= in_acc ? ST_READ : ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

`ifndef SYNTHESIS
    a_read_then_update: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_READ) |=> (r_state == ST_UPDATE))
        else $error("set read not followed by update");

    a_result_from_update: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == ST_UPDATE))
        else $error("result raised outside of an update");

    a_hit_no_evict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tdata[OUT_HIT_BIT]) |-> !m_axis_tdata[OUT_EVICT_BIT])
        else $error("hit reported together with an eviction");

    a_wb_needs_evict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tdata[OUT_WB_BIT]) |-> m_axis_tdata[OUT_EVICT_BIT])
        else $error("write-back reported without an eviction");
`endif

endmodule

FILE: rtl/salc_way_update.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// salc_way_update
// Tag match, victim choice and LRU rank update for one set row.
// ----------------------------------------------------------------------------
module salc_way_update
    import salc_pkg::*;
#(
    parameter int WAYS = WAYS_DEF
) (
    input  logic [WAYS-1:0]                                i_valid,
    input  logic [WAYS-1:0]                                i_dirty,
    input  logic [WAYS*((WAYS > 1) ? $clog2(WAYS) : 1)-1:0] i_rank,
    input  logic [WAYS*KEY_W-1:0]                          i_tag,
    input  logic [KEY_W-1:0]                               i_key,
    input  logic                                           i_store,
    input  logic [$clog2(WAYS+1)-1:0]                      i_nways,
    output logic [WAYS-1:0]                                o_valid,
    output logic [WAYS-1:0]                                o_dirty,
    output logic [WAYS*((WAYS > 1) ? $clog2(WAYS) : 1)-1:0] o_rank,
    output logic [WAYS*KEY_W-1:0]                          o_tag,
    output t_upd_flags                                     o_flags
);

    localparam int RW = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int WW = RW;

    logic [WAYS-1:0] active;
    logic [WAYS-1:0] hit_vec;
    logic [WAYS-1:0] inv_vec;
    logic [WW-1:0]   hit_sel;
    logic [WW-1:0]   inv_sel;
    logic [WW-1:0]   lru_sel;
    logic [WW-1:0]   sel;
    logic [RW-1:0]   best_rank;
    logic [RW-1:0]   old_rank;
    logic            hit;
    logic            found;
    logic            sel_dirty;

    always_comb begin
        for (int w = 0; w < WAYS; w++) begin
            active[w]  = (w < int'(i_nways));
            hit_vec[w] = active[w] & i_valid[w] & (i_tag[w*KEY_W +: KEY_W] == i_key);
            inv_vec[w] = active[w] & ~i_valid[w];
        end
    end

    always_comb begin
        hit_sel   = '0;
        inv_sel   = '0;
        for (int w = WAYS - 1; w >= 0; w--) begin
            if (hit_vec[w]) begin
                hit_sel = WW'(w);
            end
            if (inv_vec[w]) begin
                inv_sel = WW'(w);
            end
        end
        lru_sel   = '0;
        best_rank = i_rank[0 +: RW];
        for (int w = 1; w < WAYS; w++) begin
            if (active[w] && (i_rank[w*RW +: RW] > best_rank)) begin
                lru_sel   = WW'(w);
                best_rank = i_rank[w*RW +: RW];
            end
        end
    end

    assign hit   = |hit_vec;
    assign found = |inv_vec;

    always_comb begin
        if (hit) begin
            sel      = hit_sel;
            old_rank = i_rank[hit_sel*RW +: RW];
        end else if (found) begin
            sel      = inv_sel;
            old_rank = RW'(WAYS - 1);
        end else begin
            sel      = lru_sel;
            old_rank = best_rank;
        end
    end

    assign sel_dirty = i_dirty[sel];

    always_comb begin
        o_valid = i_valid;
        o_dirty = i_dirty;
        o_tag   = i_tag;
        o_rank  = i_rank;
        for (int v = 0; v < WAYS; v++) begin
            if (active[v] && (v != int'(sel)) && i_valid[v]
                && (i_rank[v*RW +: RW] < old_rank)) begin
                o_rank[v*RW +: RW] = i_rank[v*RW +: RW] + RW'(1);
            end
        end
        o_rank[sel*RW +: RW] = '0;
        if (!hit) begin
            o_valid[sel]                = 1'b1;
            o_tag[sel*KEY_W +: KEY_W]   = i_key;
            o_dirty[sel]                = i_store;
        end else if (i_store) begin
            o_dirty[sel] = 1'b1;
        end
    end

    always_comb begin
        o_flags.hit       = hit;
        o_flags.evicted   = ~hit & ~found;
        o_flags.wb        = ~hit & ~found & sel_dirty;
        o_flags.dirty_inc = i_store & ((~hit & found) | ~sel_dirty);
        o_flags.dirty_dec = ~hit & ~found & ~i_store & sel_dirty;
    end

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking testbench for the set-associative LRU write-back cache model.
// A short table of directed requests exercises fills, hits, dirty evictions,
// aliased sets, duplicate tags and out-of-range settings. Randomized phases
// with varied register settings follow. Every result is compared field by
// field against a cache predictor in the testbench (the first three rows
// against values in the table). Both stream sides idle and stall at random,
// and the receiver holds off once for a long stretch so the block fills up.
// ----------------------------------------------------------------------------
module testbench
    import salc_pkg::*;
();

    localparam int WAYS_N       = WAYS_DEF;
    localparam int SETS_N       = SETS_DEF;
    localparam int LINES        = SETS_N * WAYS_N;
    localparam int MAX_OFF      = MAX_OFFSET_BITS_DEF;
    localparam int DIR_ROWS     = 35;
    localparam int PHASES       = 10;
    localparam int PHASE_ITEMS  = 123;
    localparam int DRAIN_CYCLES = 6;
    localparam int LONG_HOLD    = 300;
    localparam int IDLE_LIMIT   = 4000;

    localparam logic KIND_LOAD  = 1'b0;
    localparam logic KIND_STORE = 1'b1;
    localparam logic [CFG_IDX_W-1:0] CFG_NO_REG = 2'd3;

    typedef enum logic {
        ROW_ACCESS,
        ROW_CFG
    } t_row_op;

    typedef enum logic [1:0] {
        RX_OPEN,
        RX_RANDOM,
        RX_SPARSE
    } t_rx_mode;

    typedef struct packed {
        logic             hit;
        logic             evicted;
        logic             wb;
        logic [CNT_W-1:0] hits;
        logic [CNT_W-1:0] misses;
        logic [CNT_W-1:0] evictions;
        logic [RES_W-1:0] resident;
        logic [CNT_W-1:0] written_back;
    } t_cache_result;

    typedef struct packed {
        t_row_op               op;
        logic                  kind;
        logic [ADDR_W-1:0]     addr;
        logic [CFG_IDX_W-1:0]  reg_idx;
        logic [CFG_DATA_W-1:0] reg_val;
        logic                  typed;
        t_cache_result         exp;
    } t_stim_row;

    localparam t_cache_result NO_RESULT = '0;

    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [ADDR_W-1:0]     s_axis_tdata  = '0;   // address[63:0]
    logic                  s_axis_tuser  = 1'b0; // kind
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    // hit, evicted, dirty_writeback, hit_total[31:0], miss_total[31:0],
    // eviction_total[31:0], dirty_bytes_resident[21:0],
    // dirty_bytes_written_back[31:0], zero fill
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  i_cfg_valid   = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index   = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data    = '0;

    set_assoc_lru_cache_model u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always #1 i_clk = ~i_clk;

    // Predicted cache contents and settings.
    logic                  pr_valid [LINES];
    logic                  pr_dirty [LINES];
    logic [KEY_W-1:0]      pr_tag   [LINES];
    logic [2:0]            pr_rank  [LINES];
    logic [CNT_W-1:0]      pr_hits;
    logic [CNT_W-1:0]      pr_misses;
    logic [CNT_W-1:0]      pr_evictions;
    logic [RES_W-1:0]      pr_resident;
    logic [CNT_W-1:0]      pr_written_back;
    logic [2:0]            cfg_set_bits;
    logic [CFG_DATA_W-1:0] cfg_offset_bits;
    logic [CFG_DATA_W-1:0] cfg_ways;

    t_cache_result expected_results [$];
    int            error_count = 0;
    logic          long_hold_req = 1'b0;

    t_stim_row     directed_rows [DIR_ROWS];
    logic [63:0]   tag_pool [16];

    function automatic logic [CNT_W-1:0] sat_add32(logic [CNT_W-1:0] a, logic [63:0] b);
        logic [64:0] sum;
        sum = {33'd0, a} + {1'b0, b};
        return (sum > 65'hFFFF_FFFF) ? '1 : sum[CNT_W-1:0];
    endfunction

    function automatic logic [RES_W-1:0] sat_add22(logic [RES_W-1:0] a, logic [63:0] b);
        logic [64:0] sum;
        sum = {43'd0, a} + {1'b0, b};
        return (sum > 65'h3F_FFFF) ? '1 : sum[RES_W-1:0];
    endfunction

    function automatic void make_recent(int unsigned base, int unsigned n, int unsigned w,
                                        int unsigned old_rank);
        for (int unsigned v = 0; v < n; v++) begin
            if (v != w && pr_valid[base + v] && pr_rank[base + v] < old_rank)
                pr_rank[base + v] = pr_rank[base + v] + 3'd1;
        end
        pr_rank[base + w] = 3'd0;
    endfunction

    function automatic t_cache_result predict_access(logic store, logic [ADDR_W-1:0] addr);
        t_cache_result r;
        int unsigned   b;
        int unsigned   n;
        int unsigned   base;
        int unsigned   sel;
        int unsigned   best;
        logic [63:0]   key;
        logic [63:0]   bytes;
        logic [6:0]    set_field;
        logic          found;
        r = NO_RESULT;
        b = (cfg_offset_bits > MAX_OFF) ? MAX_OFF : int'(cfg_offset_bits);
        n = (cfg_ways == 0) ? 1 : ((cfg_ways > WAYS_N) ? WAYS_N : int'(cfg_ways));
        bytes = 64'd1 << b;
        key = addr >> b;
        set_field = key[6:0] & ((7'd1 << cfg_set_bits) - 7'd1);
        base = (int'(set_field) % SETS_N) * WAYS_N;
        sel = 0;
        found = 1'b0;
        for (int unsigned w = 0; w < n; w++) begin
            if (!found && pr_valid[base + w] && pr_tag[base + w] == key) begin
                found = 1'b1;
                sel = w;
            end
        end
        if (found) begin
            r.hit = 1'b1;
            pr_hits = sat_add32(pr_hits, 64'd1);
            if (store && !pr_dirty[base + sel]) begin
                pr_dirty[base + sel] = 1'b1;
                pr_resident = sat_add22(pr_resident, bytes);
            end
            make_recent(base, n, sel, pr_rank[base + sel]);
        end else begin
            pr_misses = sat_add32(pr_misses, 64'd1);
            for (int unsigned w = 0; w < n; w++) begin
                if (!found && !pr_valid[base + w]) begin
                    found = 1'b1;
                    sel = w;
                end
            end
            if (found) begin
                pr_valid[base + sel] = 1'b1;
                pr_tag[base + sel] = key;
                pr_dirty[base + sel] = store;
                if (store)
                    pr_resident = sat_add22(pr_resident, bytes);
                make_recent(base, n, sel, WAYS_N - 1);
            end else begin
                best = 0;
                for (int unsigned w = 1; w < n; w++) begin
                    if (pr_rank[base + w] > pr_rank[base + best])
                        best = w;
                end
                sel = best;
                r.evicted = 1'b1;
                pr_evictions = sat_add32(pr_evictions, 64'd1);
                r.wb = pr_dirty[base + sel];
                if (r.wb)
                    pr_written_back = sat_add32(pr_written_back, bytes);
                if (store) begin
                    if (!r.wb)
                        pr_resident = sat_add22(pr_resident, bytes);
                    pr_dirty[base + sel] = 1'b1;
                end else if (r.wb) begin
                    pr_resident = (pr_resident < bytes) ? '0 : pr_resident - bytes[RES_W-1:0];
                    pr_dirty[base + sel] = 1'b0;
                end
                pr_tag[base + sel] = key;
                make_recent(base, n, sel, pr_rank[base + sel]);
            end
        end
        r.hits = pr_hits;
        r.misses = pr_misses;
        r.evictions = pr_evictions;
        r.resident = pr_resident;
        r.written_back = pr_written_back;
        return r;
    endfunction

    task automatic compare_field(string name, logic [63:0] exp_val, logic [63:0] act_val);
        if (exp_val !== act_val) begin
            $error("%s: expected %0d, got %0d", name, exp_val, act_val);
            error_count++;
        end
    endtask

    task automatic check_result(logic [OUT_DATA_W-1:0] d);
        t_cache_result e;
        if (expected_results.size() == 0) begin
            $error("result with no request outstanding: %h", d);
            error_count++;
        end else begin
            e = expected_results.pop_front();
            compare_field("hit", 64'(e.hit), 64'(d[OUT_HIT_BIT]));
            compare_field("evicted", 64'(e.evicted), 64'(d[OUT_EVICT_BIT]));
            compare_field("dirty_writeback", 64'(e.wb), 64'(d[OUT_WB_BIT]));
            compare_field("hit_total", 64'(e.hits), 64'(d[OUT_HITS_LSB +: CNT_W]));
            compare_field("miss_total", 64'(e.misses), 64'(d[OUT_MISS_LSB +: CNT_W]));
            compare_field("eviction_total", 64'(e.evictions),
                          64'(d[OUT_EVCT_LSB +: CNT_W]));
            compare_field("dirty_bytes_resident", 64'(e.resident),
                          64'(d[OUT_RES_LSB +: RES_W]));
            compare_field("dirty_bytes_written_back", 64'(e.written_back),
                          64'(d[OUT_WBB_LSB +: CNT_W]));
        end
    endtask

    task automatic push_access(logic kind, logic [ADDR_W-1:0] addr, logic typed,
                               t_cache_result typed_res);
        t_cache_result r;
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= kind;
        s_axis_tdata  <= addr;
        do @(posedge i_clk); while (!s_axis_tready);
        r = predict_access(kind, addr);
        expected_results.push_back(typed ? typed_res : r);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_SET_INDEX_BITS:    cfg_set_bits = val[2:0];
            CFG_BLOCK_OFFSET_BITS: cfg_offset_bits = val;
            CFG_WAYS_IN_USE:       cfg_ways = val;
            default: ;
        endcase
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Receiver: changing stall patterns plus one long hold-off on request.
    t_rx_mode    rx_mode = RX_OPEN;
    int unsigned rx_window = 0;
    int unsigned rx_tick = 0;
    int unsigned hold_count = 0;
    logic        long_hold_done = 1'b0;

    always @(posedge i_clk) begin
        if (m_axis_tvalid && m_axis_tready)
            check_result(m_axis_tdata);
        rx_tick++;
        if (rx_window == 0) begin
            rx_mode = t_rx_mode'($urandom_range(0, 2));
            rx_window = $urandom_range(16, 80);
        end else begin
            rx_window--;
        end
        if (long_hold_req && !long_hold_done) begin
            m_axis_tready <= 1'b0;
            if (hold_count == LONG_HOLD)
                long_hold_done = 1'b1;
            else
                hold_count++;
        end else begin
            case (rx_mode)
                RX_OPEN:   m_axis_tready <= 1'b1;
                RX_RANDOM: m_axis_tready <= 1'($urandom_range(0, 1));
                default:   m_axis_tready <= (rx_tick % 3 == 0);
            endcase
        end
    end

    int unsigned idle_cycles = 0;

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles == IDLE_LIMIT) begin
                $display("set_assoc_lru_cache_model: mismatch");
                $finish;
            end
        end
    end

    initial begin
        int unsigned       burst_left;
        int unsigned       gap;
        int unsigned       eb;
        int unsigned       pool_n;
        int unsigned       set_span;
        logic [63:0]       idx_mask;
        logic [63:0]       off_mask;
        logic [63:0]       set_sel;
        logic [ADDR_W-1:0] addr;
        logic [2:0]        new_set_bits;
        logic [3:0]        new_off_bits;
        logic [3:0]        new_ways;

        for (int i = 0; i < LINES; i++) begin
            pr_valid[i] = 1'b0;
            pr_dirty[i] = 1'b0;
            pr_rank[i]  = 3'd0;
        end
        pr_hits = '0;
        pr_misses = '0;
        pr_evictions = '0;
        pr_resident = '0;
        pr_written_back = '0;
        cfg_set_bits = CFG_SET_BITS_RST;
        cfg_offset_bits = CFG_OFF_BITS_RST;
        cfg_ways = CFG_WAYS_RST;
        for (int i = 0; i < 16; i++)
            tag_pool[i] = (i < 8) ? 64'(i) : {$urandom, $urandom};

        directed_rows = '{
            '{ROW_ACCESS, KIND_LOAD,  64'h0, 2'd0, 4'd0, 1'b1,
              '{1'b0, 1'b0, 1'b0, 32'd0, 32'd1, 32'd0, 22'd0, 32'd0}},
            '{ROW_ACCESS, KIND_STORE, 64'h0, 2'd0, 4'd0, 1'b1,
              '{1'b1, 1'b0, 1'b0, 32'd1, 32'd1, 32'd0, 22'd16, 32'd0}},
            '{ROW_ACCESS, KIND_STORE, 64'hFFFF_FFFF_FFFF_FFFF, 2'd0, 4'd0, 1'b1,
              '{1'b0, 1'b0, 1'b0, 32'd1, 32'd2, 32'd0, 22'd32, 32'd0}},
            '{ROW_ACCESS, KIND_LOAD,  64'h10, 2'd0, 4'd0, 1'b0, NO_RESULT},
            '{ROW_ACCESS, KIND_LOAD,  64'h20, 2'd0, 4'd0, 1'b0, NO_RESULT},
            '{ROW_ACCESS, KIND_LOAD,  64'h30, 2'd0, 4'd0, 1'b0, NO_RESULT},
            '{ROW_ACCESS, KIND_LOAD,  64'h40, 2'd0, 4'd0, 1'b0, NO_RESULT},
            '{ROW_ACCESS, KIND_LOAD,  64'h50, 2'd0, 4'd0, 1'b0, NO_RESULT},
            '{ROW_ACCESS, KIND_LOAD,  64'h60, 2'd0, 4'd0, 1'b0, NO_RESULT},
            '{ROW_ACCESS, KIND_STORE, 64'h100, 2'd0, 4'd0, 1'b0, NO_RESULT},
            '{ROW_ACCESS, KIND_LOAD,  64'h0, 2'd0, 4'd0, 1'b0, NO_RESULT},
            '{ROW_ACCESS, KIND_LOAD,  64'h10, 2'd0, 4'd0, 1'b0, NO_RESULT},
            '{ROW_CFG,    KIND_LOAD,  64'h0, CFG_WAYS_IN_USE, 4'd1, 1'b0, NO_RESULT},
            '{ROW_ACCESS, KIND_LOAD,  64'h300, 2'd0, 4'd0, 1'b0, NO_RESULT},
            '{ROW_ACCESS, KIND_LOAD,  64'h20, 2'd0, 4'd0, 1'b0, NO_RESULT},
            '{ROW_CFG,    KIND_LOAD,  64'h0, CFG_WAYS_IN_USE, 4'd0, 1'b0, NO_RESULT},
            '{ROW_ACCESS, KIND_STORE, 64'h500, 2'd0, 4'd0, 1'b0, NO_RESULT},
            '{ROW_CFG,    KIND_LOAD,  64'h0, CFG_WAYS_IN_USE, 4'd8, 1'b0, NO_RESULT},
            '{ROW_ACCESS, KIND_LOAD,  64'h20, 2'd0, 4'd0, 1'b0, NO_RESULT},
            '{ROW_CFG,    KIND_LOAD,  64'h0, CFG_WAYS_IN_USE, 4'd15, 1'b0, NO_RESULT},
            '{ROW_CFG,    KIND_LOAD,  64'h0, CFG_BLOCK_OFFSET_BITS, 4'd15, 1'b0, NO_RESULT},
            '{ROW_CFG,    KIND_LOAD,  64'h0, CFG_SET_INDEX_BITS, 4'd7, 1'b0, NO_RESULT},
            '{ROW_ACCESS, KIND_STORE, 64'hFFFF_FFFF_FFFF_F000, 2'd0, 4'd0, 1'b0, NO_RESULT},
            '{ROW_ACCESS, KIND_LOAD,  64'h0, 2'd0, 4'd0, 1'b0, NO_RESULT},
            '{ROW_ACCESS, KIND_STORE, 64'h7F000, 2'd0, 4'd0, 1'b0, NO_RESULT},
            '{ROW_ACCESS, KIND_LOAD,  64'h3F000, 2'd0, 4'd0, 1'b0, NO_RESULT},
            '{ROW_ACCESS, KIND_LOAD,  64'h7F000, 2'd0, 4'd0, 1'b0, NO_RESULT},
            '{ROW_CFG,    KIND_LOAD,  64'h0, CFG_BLOCK_OFFSET_BITS, 4'd0, 1'b0, NO_RESULT},
            '{ROW_CFG,    KIND_LOAD,  64'h0, CFG_SET_INDEX_BITS, 4'd6, 1'b0, NO_RESULT},
            '{ROW_ACCESS, KIND_LOAD,  64'h3F, 2'd0, 4'd0, 1'b0, NO_RESULT},
            '{ROW_ACCESS, KIND_STORE, 64'h40, 2'd0, 4'd0, 1'b0, NO_RESULT},
            '{ROW_ACCESS, KIND_LOAD,  64'h7F, 2'd0, 4'd0, 1'b0, NO_RESULT},
            '{ROW_CFG,    KIND_LOAD,  64'h0, CFG_BLOCK_OFFSET_BITS, 4'd4, 1'b0, NO_RESULT},
            '{ROW_CFG,    KIND_LOAD,  64'h0, CFG_SET_INDEX_BITS, 4'd0, 1'b0, NO_RESULT},
            '{ROW_ACCESS, KIND_LOAD,  64'h8000_0000_0000_0000, 2'd0, 4'd0, 1'b0, NO_RESULT}
        };

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int i = 0; i < DIR_ROWS; i++) begin
            if (directed_rows[i].op == ROW_CFG) begin
                wait_drained();
                write_reg(directed_rows[i].reg_idx, directed_rows[i].reg_val);
            end else begin
                push_access(directed_rows[i].kind, directed_rows[i].addr,
                            directed_rows[i].typed, directed_rows[i].exp);
            end
        end

        burst_left = 0;
        for (int p = 0; p < PHASES; p++) begin
            wait_drained();
            case (p)
                0: begin new_set_bits = 3'd0; new_off_bits = 4'd0;  new_ways = 4'd1;  end
                1: begin new_set_bits = 3'd6; new_off_bits = 4'd12; new_ways = 4'd8;  end
                2: begin new_set_bits = 3'd7; new_off_bits = 4'd15; new_ways = 4'd15; end
                3: begin new_set_bits = 3'd3; new_off_bits = 4'd4;  new_ways = 4'd0;  end
                default: begin
                    new_set_bits = 3'($urandom_range(0, 7));
                    new_off_bits = 4'($urandom_range(0, 15));
                    new_ways     = 4'($urandom_range(0, 15));
                end
            endcase
            write_reg(CFG_SET_INDEX_BITS, {1'b0, new_set_bits});
            write_reg(CFG_BLOCK_OFFSET_BITS, new_off_bits);
            write_reg(CFG_WAYS_IN_USE, new_ways);
            if (p == 0)
                write_reg(CFG_NO_REG, 4'($urandom_range(0, 15)));
            if (p == 2)
                long_hold_req <= 1'b1;

            eb = (cfg_offset_bits > MAX_OFF) ? MAX_OFF : int'(cfg_offset_bits);
            pool_n = $urandom_range(1, 16);
            case ($urandom_range(0, 3))
                0: set_span = 1;
                1: set_span = 2;
                2: set_span = 4;
                default: set_span = 128;
            endcase
            idx_mask = (64'd1 << cfg_set_bits) - 64'd1;
            off_mask = (64'd1 << eb) - 64'd1;

            for (int k = 0; k < PHASE_ITEMS; k++) begin
                if (burst_left == 0) begin
                    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
                    if (gap != 0) begin
                        s_axis_tvalid <= 1'b0;
                        repeat (gap) @(posedge i_clk);
                    end
                    burst_left = $urandom_range(1, 16);
                end
                burst_left--;
                if ($urandom_range(0, 9) == 0) begin
                    addr = {$urandom, $urandom};
                end else begin
                    set_sel = 64'($urandom_range(0, set_span - 1));
                    addr = (tag_pool[$urandom_range(0, pool_n - 1)] << (eb + cfg_set_bits))
                         | ((set_sel & idx_mask) << eb)
                         | ({$urandom, $urandom} & off_mask);
                end
                push_access(1'($urandom_range(0, 1)), addr, 1'b0, NO_RESULT);
            end
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (error_count == 0 && expected_results.size() == 0) begin
            $display("set_assoc_lru_cache_model: match");
        end else begin
            $display("set_assoc_lru_cache_model: mismatch");
        end
        $finish;
    end

endmodule
